// ===== hdl/clock_digit_roll_animation_macros.svh =====
// ----------------------------------------------------------------------------
// Clock digit roll animation assertion macros
// Shared concurrent assertion forms used by the roll animation RTL.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DIGIT_ROLL_ANIMATION_MACROS_SVH
`define CLOCK_DIGIT_ROLL_ANIMATION_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define CDRA_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("cdra invariant violated");

// Consequent must hold in the same cycle as the antecedent
`define CDRA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cdra same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define CDRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cdra next-cycle check failed");

`endif

// ===== hdl/cdra_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock digit roll animation package
// Types, constants and small helper functions shared by the roll RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package cdra_pkg;

    // Field widths
    localparam int ELAPSED_W = 13;
    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int DIGIT_W   = 4;

    // Lanes: hour tens, hour ones, minute tens, minute ones
    localparam int NUM_LANES = 4;
    localparam int LANE_HT   = 0;
    localparam int LANE_HO   = 1;
    localparam int LANE_MT   = 2;
    localparam int LANE_MO   = 3;

    localparam logic [ELAPSED_W-1:0] LANE_END_MS [NUM_LANES] = '{
        13'd5000, 13'd4000, 13'd3000, 13'd2000
    };

    // Roll speed
    localparam int DIGITS_PER_SECOND = 20;
    localparam int MS_PER_DIGIT      = 1000 / DIGITS_PER_SECOND;
    // Time of one step in the 2*steps/R sense, also the decel divisor scale
    localparam int STEP_MS           = 2000 / DIGITS_PER_SECOND;
    // STEP_MS*extra - lane_end is 1000 ms on every lane, i.e. 10 steps
    localparam int RUN_BASE          = 10;
    localparam int RUN_W             = 5;

    // Linear phase: floor(t/50) as a reciprocal multiply, exact for t < 2048
    localparam int RECIP_SHIFT = 16;
    localparam int LIN_RECIP   = (2**RECIP_SHIFT + MS_PER_DIGIT - 1) / MS_PER_DIGIT;
    localparam int LIN_PROD_W  = 24;
    localparam int LIN_POS_W   = 6;

    // Decel phase arithmetic
    localparam int PROD_W   = 26;
    localparam int REM_W    = PROD_W + 1;
    localparam int DIVR_W   = 20;
    localparam int DIV_BITS = 7;
    localparam int POS_W    = DIV_BITS;
    localparam int SUM_W    = 8;

    // mod 10 by reciprocal, exact below 1029
    localparam int MOD10_MUL   = 205;
    localparam int MOD10_SHIFT = 11;
    localparam int MOD10_PW    = 16;

    // Pipeline: decode stage + lane stages (setup, multiply, subtract,
    // one per quotient bit, digit)
    localparam int LANE_LATENCY = 4 + DIV_BITS;
    localparam int PIPE_DEPTH   = 1 + LANE_LATENCY;

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_TWENTYFOUR_HOUR = 1'b0;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef enum logic [1:0] {
        PH_LINEAR,
        PH_DECEL,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        digit_t               d_prev;
        digit_t               d_new;
    } lane_in_t;

    typedef struct packed {
        phase_t                 phase;
        logic [LIN_POS_W-1:0]   lin_pos;
        digit_t                 d_prev;
        digit_t                 d_new;
    } lane_side_t;

    typedef struct packed {
        digit_t hour_tens;
        digit_t hour_ones;
        digit_t minute_tens;
        digit_t minute_ones;
    } disp_t;

    // Tens digit of a value 0..63
    function automatic digit_t tens_of(input logic [MINUTES_W-1:0] v);
        digit_t q;
        q = '0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= MINUTES_W'(10 * k)) begin
                q = DIGIT_W'(k);
            end
        end
        return q;
    endfunction

    // Ones digit of a value 0..63
    function automatic digit_t ones_of(input logic [MINUTES_W-1:0] v);
        logic [MINUTES_W-1:0] tens_x10;
        tens_x10 = MINUTES_W'({2'b00, tens_of(v)} * MINUTES_W'(10));
        return DIGIT_W'(v - tens_x10);
    endfunction

    // v mod 10 for small v
    function automatic digit_t mod10(input logic [SUM_W-1:0] v);
        logic [MOD10_PW-1:0] p;
        logic [SUM_W-1:0]    q;
        p = MOD10_PW'(v) * MOD10_PW'(MOD10_MUL);
        q = SUM_W'(p >> MOD10_SHIFT);
        return DIGIT_W'(v - SUM_W'(q * SUM_W'(10)));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cdra_decode.sv =====
// ----------------------------------------------------------------------------
// Clock digit roll animation time decode
// Converts the hour to the display form, finds the previous minute's time and
// splits both times into per-lane start and end digits. One register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cdra_decode import cdra_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  twentyfour_hour,
    input  logic [ELAPSED_W-1:0]  elapsed_ms,
    input  logic [HOURS_W-1:0]    hours,
    input  logic [MINUTES_W-1:0]  minutes,
    output lane_in_t [NUM_LANES-1:0] lane_in
);

    logic [HOURS_W-1:0]   hr_w;
    logic [HOURS_W-1:0]   prev_hr_w;
    logic [MINUTES_W-1:0] prev_mn_w;
    lane_in_t [NUM_LANES-1:0] lane_next;
    lane_in_t [NUM_LANES-1:0] lane_reg;

    // Displayed hour: 12-hour form maps 0 to 12 and folds 13 and up
    always_comb begin
        hr_w = hours;
        if (!twentyfour_hour) begin
            if (hours == '0) begin
                hr_w = HOURS_W'(12);
            end else if (hours > HOURS_W'(12)) begin
                hr_w = hours - HOURS_W'(12);
            end
        end
    end

    // Previous minute, with the hour wrap on minute zero
    always_comb begin
        if (minutes != '0) begin
            prev_mn_w = minutes - MINUTES_W'(1);
            prev_hr_w = hr_w;
        end else begin
            prev_mn_w = MINUTES_W'(59);
            if (twentyfour_hour) begin
                prev_hr_w = (hr_w == '0) ? HOURS_W'(23) : hr_w - HOURS_W'(1);
            end else begin
                prev_hr_w = (hr_w == HOURS_W'(1)) ? HOURS_W'(12) : hr_w - HOURS_W'(1);
            end
        end
    end

    // Digit split per lane
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_next[i].elapsed = elapsed_ms;
        end
        lane_next[LANE_HT].d_prev = tens_of(MINUTES_W'(prev_hr_w));
        lane_next[LANE_HT].d_new  = tens_of(MINUTES_W'(hr_w));
        lane_next[LANE_HO].d_prev = ones_of(MINUTES_W'(prev_hr_w));
        lane_next[LANE_HO].d_new  = ones_of(MINUTES_W'(hr_w));
        lane_next[LANE_MT].d_prev = tens_of(prev_mn_w);
        lane_next[LANE_MT].d_new  = tens_of(minutes);
        lane_next[LANE_MO].d_prev = ones_of(prev_mn_w);
        lane_next[LANE_MO].d_new  = ones_of(minutes);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_in = lane_reg;

endmodule

`default_nettype wire

// ===== hdl/cdra_lane.sv =====
// ----------------------------------------------------------------------------
// Clock digit roll animation lane
// One digit lane: phase select, decel numerator, pipelined restoring divider
// (one quotient bit per stage) and final digit mod 10.
// ----------------------------------------------------------------------------
`default_nettype none

module cdra_lane import cdra_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ELAPSED_W-1:0]  lane_end_ms,
    input  lane_in_t              lane_in,
    output digit_t                digit
);

    // Setup stage signals
    logic [RUN_W-1:0]      run_steps_w;
    logic [ELAPSED_W-1:0]  t0_w;
    logic [LIN_PROD_W-1:0] lin_prod_w;
    lane_side_t            side_w;

    logic [ELAPSED_W-1:0]  elapsed1_reg;
    logic [ELAPSED_W-1:0]  span1_reg;
    logic [ELAPSED_W-1:0]  u1_reg;
    lane_side_t            side1_reg;

    // Multiply stage
    logic [PROD_W-1:0]     dt2_reg;
    logic [PROD_W-1:0]     uu2_reg;
    logic [DIVR_W-1:0]     divr2_reg;
    lane_side_t            side2_reg;

    // Divider stages; index 0 holds the numerator
    logic [REM_W-1:0]      rem_reg  [DIV_BITS+1];
    logic [DIVR_W-1:0]     divr_reg [DIV_BITS+1];
    logic [POS_W-1:0]      quo_reg  [DIV_BITS+1];
    lane_side_t            side_reg [DIV_BITS+1];
    logic [REM_W-1:0]      sh_w     [DIV_BITS];
    logic                  ge_w     [DIV_BITS];

    // Digit stage
    logic [POS_W-1:0]      pos_w;
    digit_t                digit_next;
    digit_t                digit_reg;

    // Decel start T0 = 100*(10 + new - prev), always 100..1900 ms
    always_comb begin
        run_steps_w = RUN_W'(RUN_W'(RUN_BASE) + RUN_W'(lane_in.d_new)
                      - RUN_W'(lane_in.d_prev));
        t0_w        = ELAPSED_W'(run_steps_w) * ELAPSED_W'(STEP_MS);
        lin_prod_w  = LIN_PROD_W'(lane_in.elapsed) * LIN_PROD_W'(LIN_RECIP);
        side_w.lin_pos = lin_prod_w[RECIP_SHIFT +: LIN_POS_W];
        side_w.d_prev  = lane_in.d_prev;
        side_w.d_new   = lane_in.d_new;
        priority if (lane_in.elapsed >= lane_end_ms) begin
            side_w.phase = PH_DONE;
        end else if (lane_in.elapsed <= t0_w) begin
            side_w.phase = PH_LINEAR;
        end else begin
            side_w.phase = PH_DECEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            elapsed1_reg <= lane_in.elapsed;
            span1_reg    <= lane_end_ms - t0_w;
            u1_reg       <= lane_in.elapsed - t0_w;
            side1_reg    <= side_w;
        end
    end

    // D*T, U*U and divisor 100*D
    always_ff @(posedge aclk) begin
        if (en) begin
            dt2_reg   <= PROD_W'(span1_reg) * PROD_W'(elapsed1_reg);
            uu2_reg   <= PROD_W'(u1_reg) * PROD_W'(u1_reg);
            divr2_reg <= DIVR_W'(span1_reg) * DIVR_W'(STEP_MS);
            side2_reg <= side1_reg;
        end
    end

    // Restoring divide step compares
    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            sh_w[k] = REM_W'(divr_reg[k]) << (DIV_BITS - 1 - k);
            ge_w[k] = (rem_reg[k] >= sh_w[k]);
        end
    end

    // Numerator 2*D*T - U*U, then one quotient bit per stage, MSB first
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= REM_W'({dt2_reg, 1'b0}) - REM_W'(uu2_reg);
            divr_reg[0] <= divr2_reg;
            quo_reg[0]  <= '0;
            side_reg[0] <= side2_reg;
            for (int k = 0; k < DIV_BITS; k++) begin
                rem_reg[k+1]  <= ge_w[k] ? rem_reg[k] - sh_w[k] : rem_reg[k];
                divr_reg[k+1] <= divr_reg[k];
                quo_reg[k+1]  <= {quo_reg[k][POS_W-2:0], ge_w[k]};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Digit shown: the new digit once done, else position plus start digit, mod 10
    always_comb begin
        pos_w = quo_reg[DIV_BITS];
        unique case (side_reg[DIV_BITS].phase)
            PH_DONE: begin
                digit_next = side_reg[DIV_BITS].d_new;
            end
            PH_LINEAR: begin
                digit_next = mod10(SUM_W'(side_reg[DIV_BITS].lin_pos)
                                   + SUM_W'(side_reg[DIV_BITS].d_prev));
            end
            default: begin
                digit_next = mod10(SUM_W'(pos_w) + SUM_W'(side_reg[DIV_BITS].d_prev));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

// ===== hdl/cdra_outbuf.sv =====
// ----------------------------------------------------------------------------
// Clock digit roll animation output merge
// Gathers the four lane digits into one result beat and holds it in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_digit_roll_animation_macros.svh"

module cdra_outbuf import cdra_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  digit_t [NUM_LANES-1:0]    lane_digit,
    output logic                      en,
    output logic                      out_valid,
    input  logic                      out_ready,
    output disp_t                     out_disp
);

    disp_t  merged_w;
    logic   in_fire_w;

    logic   main_valid_reg;
    logic   main_valid_next;
    disp_t  main_reg;
    disp_t  main_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    disp_t  skid_reg;
    disp_t  skid_next;

    // Merge lanes into one display beat
    always_comb begin
        merged_w.hour_tens   = lane_digit[LANE_HT];
        merged_w.hour_ones   = lane_digit[LANE_HO];
        merged_w.minute_tens = lane_digit[LANE_MT];
        merged_w.minute_ones = lane_digit[LANE_MO];
    end

    // Pipeline moves whenever the skid slot is free
    assign en        = !skid_valid_reg;
    assign in_fire_w = in_valid && en;

    // Main/skid update
    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (main_valid_reg && !out_ready) begin
            if (in_fire_w) begin
                skid_valid_next = 1'b1;
                skid_next       = merged_w;
            end
        end else if (skid_valid_reg) begin
            main_valid_next = 1'b1;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            main_valid_next = in_fire_w;
            main_next       = merged_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_disp  = main_reg;

    // Skid only fills behind a full main register
    `CDRA_ASSERT_ALWAYS(a_skid_behind_main, aclk, aresetn, !skid_valid_reg || main_valid_reg)
    // A beat arriving against a stalled main register lands in the skid slot
    `CDRA_ASSERT_NEXT(a_stall_to_skid, aclk, aresetn, in_fire_w && main_valid_reg && !out_ready, skid_valid_reg)
    // Full skid stays full while the receiver stalls
    `CDRA_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !out_ready, skid_valid_reg && $stable(skid_reg))

endmodule

`default_nettype wire

// ===== hdl/clock_digit_roll_animation.sv =====
// ----------------------------------------------------------------------------
// Clock digit roll animation
// Four-lane rolling digit generator for an hour:minute display.
//
// Usage:
//   s_ channel: one beat per animation frame carries elapsed_ms, hours
//   (24-hour form) and minutes. m_ channel: one beat per input beat with the
//   four digits to show. Beats stay in order.
//   Path of a beat: 1 decode, 3 setup/multiply/subtract, 7 divider, 1 digit
//   and 1 output register stage. Throughput: one beat per cycle while the
//   skid register is empty; each lane has its own pipelined restoring divider
//   producing one quotient bit per stage.
//   Config: APB register 0 (twentyfour_hour, bit 0). Write it only while no
//   beats are in flight. pready is tied high.
//   Reset: aresetn low clears all valid state and selects 12-hour mode.
//   Stall: when m_ready is low the result waits in the output register; one
//   more beat is caught in a skid register, after which s_ready drops and the
//   whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_digit_roll_animation_macros.svh"

module clock_digit_roll_animation import cdra_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // Input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ELAPSED_W-1:0]   s_elapsed_ms,
    input  logic [HOURS_W-1:0]     s_hours,
    input  logic [MINUTES_W-1:0]   s_minutes,
    // Result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DIGIT_W-1:0]     m_hour_tens,
    output logic [DIGIT_W-1:0]     m_hour_ones,
    output logic [DIGIT_W-1:0]     m_minute_tens,
    output logic [DIGIT_W-1:0]     m_minute_ones
);

    logic                     en;
    logic [CFG_IDX_W-1:0]     cfg_idx_w;
    logic                     cfg_wr_w;
    logic                     cfg_wr_mode_w;
    logic                     twentyfour_reg;
    logic [PIPE_DEPTH-1:0]    vld_reg;
    logic [PIPE_DEPTH-1:0]    vld_next;
    logic                     tail_vld_w;
    lane_in_t [NUM_LANES-1:0] lane_in;
    digit_t [NUM_LANES-1:0]   lane_digit;
    disp_t                    out_disp;
    logic                     digits_ok_w;

    // Register port
    assign cfg_idx_w     = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr_w      = psel && penable && pwrite && pready;
    assign cfg_wr_mode_w = cfg_wr_w && (cfg_idx_w == REG_TWENTYFOUR_HOUR);
    assign pready        = 1'b1;
    assign prdata        = (cfg_idx_w == REG_TWENTYFOUR_HOUR)
                           ? CFG_DATA_W'(twentyfour_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            twentyfour_reg <= 1'b0;
        end else if (cfg_wr_mode_w) begin
            twentyfour_reg <= pwdata[0];
        end
    end

    // Beat valid chain alongside the lane pipelines
    assign s_ready    = en;
    assign vld_next   = {vld_reg[PIPE_DEPTH-2:0], s_valid};
    assign tail_vld_w = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    cdra_decode u_decode (
        .aclk            (aclk),
        .en              (en),
        .twentyfour_hour (twentyfour_reg),
        .elapsed_ms      (s_elapsed_ms),
        .hours           (s_hours),
        .minutes         (s_minutes),
        .lane_in         (lane_in)
    );

    // One core per displayed digit
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        cdra_lane u_lane (
            .aclk        (aclk),
            .en          (en),
            .lane_end_ms (LANE_END_MS[i]),
            .lane_in     (lane_in[i]),
            .digit       (lane_digit[i])
        );
    end

    cdra_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (tail_vld_w),
        .lane_digit (lane_digit),
        .en         (en),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_disp   (out_disp)
    );

    assign m_hour_tens   = out_disp.hour_tens;
    assign m_hour_ones   = out_disp.hour_ones;
    assign m_minute_tens = out_disp.minute_tens;
    assign m_minute_ones = out_disp.minute_ones;

    // All four shown digits are decimal
    assign digits_ok_w = (m_hour_tens <= 4'd9) && (m_hour_ones <= 4'd9)
                         && (m_minute_tens <= 4'd9) && (m_minute_ones <= 4'd9);

    // Mode register follows a write to its address
    `CDRA_ASSERT_NEXT(a_cfg_write, aclk, aresetn, cfg_wr_mode_w, twentyfour_reg == $past(pwdata[0]))
    // Stalled beat at the pipeline end is not dropped
    `CDRA_ASSERT_NEXT(a_tail_held, aclk, aresetn, tail_vld_w && !s_ready, tail_vld_w)
    // Every shown digit is decimal
    `CDRA_ASSERT_SAME(a_digits_decimal, aclk, aresetn, m_valid, digits_ok_w)

endmodule

`default_nettype wire
